### rtl/core/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for the rational reduce block
// operation codes and widths, but no front-to-back job record
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int OperandWidth = 16;
  localparam int NumOutWidth  = 32;
  localparam int DenOutWidth  = 31;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

endpackage

### rtl/core/rar_if.sv
// ----------------------------------------------------------------------------
// rar_if: valid/ready channel with a parameterized payload
// carries one item per handshake
// ----------------------------------------------------------------------------
interface rar_if #(
  parameter int PayloadWidth = 8
);
  logic                    valid;
  logic                    ready;
  logic [PayloadWidth-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/rar_front.sv
// ----------------------------------------------------------------------------
// rar_front: operand classification and cross products
// flags zero denominators or divisors, forms signed numerator and denominator
// ----------------------------------------------------------------------------
module rar_front #(
  parameter int OperandWidth = rar_pkg::OperandWidth,
  localparam int XW = 2*OperandWidth + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rar_if.sink           in_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output logic          job_err_o,
  output logic          job_neg_o,
  output logic [XW-1:0] job_num_o,
  output logic [XW-1:0] job_den_o
);

  localparam int W = OperandWidth;

  logic [1:0]          cmd;
  logic signed [W-1:0] ln, rn;
  logic [W-2:0]        ld, rd;
  logic signed [XW:0]  p0, p1, num_s, den_s;
  logic                err;
  logic                valid_q, err_q, neg_q;
  logic [XW-1:0]       num_q, den_q;

  assign {cmd, ln, ld, rn, rd} = in_i.payload;
  assign err = (ld == '0) || (rd == '0) || (cmd == rar_pkg::CMD_DIV && rn == '0);

  always_comb begin
    p0 = (XW+1)'(ln) * (XW+1)'($signed({1'b0, rd}));
    p1 = (XW+1)'(rn) * (XW+1)'($signed({1'b0, ld}));
    den_s = (XW+1)'($signed({1'b0, ld})) * (XW+1)'($signed({1'b0, rd}));
    unique case (rar_pkg::cmd_e'(cmd))
      rar_pkg::CMD_ADD: num_s = p0 + p1;
      rar_pkg::CMD_SUB: num_s = p0 - p1;
      rar_pkg::CMD_MUL: num_s = (XW+1)'(ln) * (XW+1)'(rn);
      rar_pkg::CMD_DIV: begin
        num_s = p0;
        den_s = (XW+1)'($signed({1'b0, ld})) * (XW+1)'(rn);
      end
      default: num_s = '0;
    endcase
  end

  assign in_i.ready = !valid_q || job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      err_q <= err;
      neg_q <= num_s[XW] ^ den_s[XW];
      num_q <= num_s[XW] ? XW'(-num_s) : num_s[XW-1:0];
      den_q <= den_s[XW] ? XW'(-den_s) : den_s[XW-1:0];
    end
  end

  assign job_valid_o = valid_q;
  assign job_err_o   = err_q;
  assign job_neg_o   = neg_q;
  assign job_num_o   = num_q;
  assign job_den_o   = den_q;

endmodule

### rtl/core/rar_back.sv
// ----------------------------------------------------------------------------
// rar_back: binary gcd reduction of one fraction at a time
// strips common twos, subtracts to the gcd, then divides it out
// ----------------------------------------------------------------------------
module rar_back #(
  parameter int XW = 33
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  output logic                           job_ready_o,
  input  logic                           job_err_i,
  input  logic                           job_neg_i,
  input  logic [XW-1:0]                  job_num_i,
  input  logic [XW-1:0]                  job_den_i,
  rar_if.source                          out_o
);

  localparam int CW = $clog2(XW + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_TWOS, ST_GCD, ST_DIVN, ST_DIVD, ST_OUT
  } state_e;

  state_e        state_q;
  logic [XW-1:0] n_q, d_q, a_q, b_q, g_q, quo_q, rem_q, dvd_q;
  logic [CW-1:0] k_q, bit_q;
  logic          neg_q, err_q;
  logic [XW:0]   trial;

  assign trial = {rem_q, dvd_q[XW-1]} - {1'b0, g_q};
  assign job_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            n_q <= job_num_i; d_q <= job_den_i;
            a_q <= job_num_i; b_q <= job_den_i;
            neg_q <= job_neg_i; err_q <= job_err_i;
            k_q <= '0;
            state_q <= (job_err_i || job_num_i == '0) ? ST_OUT : ST_TWOS;
          end
        end
        ST_TWOS: begin
          if (!a_q[0] && !b_q[0]) begin
            a_q <= a_q >> 1; b_q <= b_q >> 1; k_q <= k_q + 1'b1;
          end else begin
            state_q <= ST_GCD;
          end
        end
        ST_GCD: begin
          if (!a_q[0]) a_q <= a_q >> 1;
          else if (!b_q[0]) b_q <= b_q >> 1;
          else if (a_q == b_q) begin
            g_q <= a_q << k_q;
            rem_q <= '0; dvd_q <= n_q; bit_q <= '0;
            state_q <= ST_DIVN;
          end else if (a_q > b_q) a_q <= (a_q - b_q) >> 1;
          else b_q <= (b_q - a_q) >> 1;
        end
        ST_DIVN, ST_DIVD: begin
          if (bit_q == CW'(XW-1)) begin
            bit_q <= '0;
            rem_q <= '0;
            if (state_q == ST_DIVN) begin
              n_q <= {quo_q[XW-2:0], ~trial[XW]};
              dvd_q <= d_q;
              state_q <= ST_DIVD;
            end else begin
              d_q <= {quo_q[XW-2:0], ~trial[XW]};
              state_q <= ST_OUT;
            end
          end else begin
            dvd_q <= dvd_q << 1;
            bit_q <= bit_q + 1'b1;
            if (!trial[XW]) begin
              rem_q <= trial[XW-1:0]; quo_q <= {quo_q[XW-2:0], 1'b1};
            end else begin
              rem_q <= {rem_q[XW-2:0], dvd_q[XW-1]}; quo_q <= {quo_q[XW-2:0], 1'b0};
            end
          end
        end
        ST_OUT: begin
          if (out_o.ready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  logic [XW-1:0] n_neg;
  logic [31:0]   num_o;
  logic [30:0]   den_o;
  assign n_neg = neg_q ? -n_q : n_q;
  always_comb begin
    if (err_q) begin
      num_o = '0; den_o = '0;
    end else if (n_q == '0) begin
      num_o = '0; den_o = 31'd1;
    end else begin
      num_o = 32'($signed({n_neg[XW-1], n_neg}));
      den_o = 31'({1'b0, d_q});
    end
  end

  assign out_o.valid   = (state_q == ST_OUT);
  assign out_o.payload = {num_o, den_o, err_q};

endmodule

### rtl/core/rational_arithmetic_reduce.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce: fraction add/sub/mul/div reduced to lowest terms
// front forms exact cross products, back reduces by binary gcd and divides
// ----------------------------------------------------------------------------
// the back end takes one item at a time: its shift-subtract divider and binary
//   gcd loop finish first, and the front register lets the next item wait ready
// reset: rst_ni asynchronous active low clears valid and state, no clear pass
module rational_arithmetic_reduce #(
  parameter int OperandWidth = rar_pkg::OperandWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  rar_if.sink  in_i,
  rar_if.source out_o
);

  localparam int XW = 2*OperandWidth + 1;

  // handoff between the classify stage and the reduce engine
  logic          job_valid, job_ready, job_err, job_neg;
  logic [XW-1:0] job_num, job_den;

  rar_front #(.OperandWidth(OperandWidth)) u_front (
    .clk_i, .rst_ni, .in_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready),
    .job_err_o(job_err), .job_neg_o(job_neg),
    .job_num_o(job_num), .job_den_o(job_den)
  );

  rar_back #(.XW(XW)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_err_i(job_err), .job_neg_i(job_neg),
    .job_num_i(job_num), .job_den_i(job_den),
    .out_o
  );

endmodule
